>>> rtl/pcts_pkg.sv
`timescale 1ns / 1ps
// shared types, byte codes and classifier functions for the content stream token splitter
// no dependencies

package pcts_pkg;

    localparam int PCTS_OFFSET_WIDTH = 32;
    localparam int PCTS_NEST_WIDTH   = 8;
    localparam int PCTS_QUEUE_DEPTH  = 4;
    localparam int PCTS_MAX_RESULTS  = 3;
    localparam int PCTS_POS_WIDTH    = 32;

    localparam logic [1:0] KIND_NUMBER = 2'd0;
    localparam logic [1:0] KIND_OPER   = 2'd1;
    localparam logic [1:0] KIND_OTHER  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // dictionary half pair held
    localparam logic [1:0] HALF_NONE = 2'd0;
    localparam logic [1:0] HALF_LT   = 2'd1;
    localparam logic [1:0] HALF_GT   = 2'd2;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SP      = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    typedef enum logic [10:0] {
        MODE_IDLE      = 11'b000_0000_0001,
        MODE_COMMENT   = 11'b000_0000_0010,
        MODE_LIT       = 11'b000_0000_0100,
        MODE_AFTER_LT  = 11'b000_0000_1000,
        MODE_HEX       = 11'b000_0001_0000,
        MODE_DICT      = 11'b000_0010_0000,
        MODE_ARRAY     = 11'b000_0100_0000,
        MODE_ARRAY_STR = 11'b000_1000_0000,
        MODE_NAME      = 11'b001_0000_0000,
        MODE_NUMBER    = 11'b010_0000_0000,
        MODE_OPER      = 11'b100_0000_0000
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]                token_kind;
        logic [PCTS_POS_WIDTH-1:0] token_begin;
        logic [PCTS_POS_WIDTH-1:0] token_end;
        logic                      last_result;
    } out_beat_t;

    typedef struct packed {
        logic [1:0]                kind;
        logic [PCTS_POS_WIDTH-1:0] pos_begin;
        logic [PCTS_POS_WIDTH-1:0] pos_end;
    } tok_rec_t;

    // results of one byte, count is 1 to 3, recs[0] goes out first
    typedef struct packed {
        logic [1:0]                           count;
        tok_rec_t [PCTS_MAX_RESULTS-1:0]      recs;
    } tok_group_t;

    function automatic logic is_ws(input logic [7:0] c);
        return c == CH_NUL || c == CH_TAB || c == CH_LF || c == CH_FF ||
               c == CH_CR || c == CH_SP;
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return c == CH_LPAREN || c == CH_RPAREN || c == CH_LT || c == CH_GT ||
               c == CH_LBRACK || c == CH_RBRACK || c == CH_LBRACE || c == CH_RBRACE ||
               c == CH_SLASH || c == CH_PERCENT;
    endfunction

    function automatic logic is_num_char(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
               c == CH_DOT;
    endfunction

endpackage

>>> rtl/pcts_front.sv
`timescale 1ns / 1ps
// front end: per-byte scanner state machine, builds the result group of each byte
// depends on pcts_pkg

module pcts_front
    import pcts_pkg::*;
#(
    parameter int OFFSET_WIDTH = PCTS_OFFSET_WIDTH,
    parameter int NEST_WIDTH   = PCTS_NEST_WIDTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       beat_accept,
    input  in_beat_t   beat,
    output logic       push,
    output tok_group_t push_group
);

    scan_mode_t              mode_reg, mode_next;
    logic                    esc_reg, esc_next;
    logic [NEST_WIDTH-1:0]   paren_reg, paren_next;
    logic [NEST_WIDTH-1:0]   bracket_reg, bracket_next;
    logic [NEST_WIDTH-1:0]   angle_reg, angle_next;
    logic [1:0]              half_reg, half_next;
    logic [OFFSET_WIDTH-1:0] offset_reg, offset_next;
    logic [OFFSET_WIDTH-1:0] start_reg, start_next;

    logic [7:0]              cur_byte;
    logic [OFFSET_WIDTH-1:0] off_plus;
    logic [OFFSET_WIDTH-1:0] start_mid;
    logic                    str_esc;
    logic [NEST_WIDTH-1:0]   str_paren;
    logic                    str_closed;
    logic                    go_idle;
    logic                    fresh;
    logic                    close_hit;
    logic [1:0]              close_kind;
    logic                    close_at_next;
    logic                    delim_hit;
    logic                    tail_hit;
    logic [1:0]              tail_kind;
    logic [1:0]              rec_cnt;
    tok_group_t              group;

    function automatic logic [NEST_WIDTH-1:0] inc_sat(input logic [NEST_WIDTH-1:0] d);
        return (d == '1) ? d : d + 1'b1;
    endfunction

    function automatic logic [NEST_WIDTH-1:0] dec_floor(input logic [NEST_WIDTH-1:0] d);
        return (d == '0) ? d : d - 1'b1;
    endfunction

    assign cur_byte = beat.data_byte;
    assign off_plus = offset_reg + 1'b1;

    // literal string byte, shared by plain strings and strings inside arrays
    always_comb
    begin
        str_esc    = esc_reg;
        str_paren  = paren_reg;
        str_closed = 1'b0;
        if (esc_reg)
        begin
            str_esc = 1'b0;
        end
        else if (cur_byte == CH_BSLASH)
        begin
            str_esc = 1'b1;
        end
        else if (cur_byte == CH_LPAREN)
        begin
            str_paren = inc_sat(paren_reg);
        end
        else if (cur_byte == CH_RPAREN)
        begin
            str_paren  = dec_floor(paren_reg);
            str_closed = (dec_floor(paren_reg) == '0);
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        esc_next      = esc_reg;
        paren_next    = paren_reg;
        bracket_next  = bracket_reg;
        angle_next    = angle_reg;
        half_next     = half_reg;
        start_next    = start_reg;
        offset_next   = off_plus;
        go_idle       = 1'b0;
        fresh         = 1'b0;
        close_hit     = 1'b0;
        close_kind    = KIND_OTHER;
        close_at_next = 1'b1;
        delim_hit     = 1'b0;
        tail_hit      = 1'b0;
        tail_kind     = KIND_OTHER;
        start_mid     = start_reg;

        unique case (mode_reg)
            MODE_COMMENT:
            begin
                if (cur_byte == CH_LF || cur_byte == CH_CR)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_LIT:
            begin
                esc_next   = str_esc;
                paren_next = str_paren;
                if (str_closed)
                begin
                    close_hit = 1'b1;
                    go_idle   = 1'b1;
                end
            end
            MODE_AFTER_LT:
            begin
                if (cur_byte == CH_LT)
                begin
                    mode_next  = MODE_DICT;
                    angle_next = {{(NEST_WIDTH-1){1'b0}}, 1'b1};
                    half_next  = HALF_NONE;
                end
                else if (cur_byte == CH_GT)
                begin
                    close_hit = 1'b1;
                    go_idle   = 1'b1;
                end
                else
                begin
                    mode_next = MODE_HEX;
                end
            end
            MODE_HEX:
            begin
                if (cur_byte == CH_GT)
                begin
                    close_hit = 1'b1;
                    go_idle   = 1'b1;
                end
            end
            MODE_DICT:
            begin
                half_next = HALF_NONE;
                if (half_reg == HALF_LT && cur_byte == CH_LT)
                begin
                    angle_next = inc_sat(angle_reg);
                end
                else if (half_reg == HALF_GT && cur_byte == CH_GT)
                begin
                    angle_next = dec_floor(angle_reg);
                    if (dec_floor(angle_reg) == '0)
                    begin
                        close_hit = 1'b1;
                        go_idle   = 1'b1;
                    end
                end
                else if (cur_byte == CH_LT)
                begin
                    half_next = HALF_LT;
                end
                else if (cur_byte == CH_GT)
                begin
                    half_next = HALF_GT;
                end
            end
            MODE_ARRAY:
            begin
                if (cur_byte == CH_LPAREN)
                begin
                    mode_next  = MODE_ARRAY_STR;
                    paren_next = {{(NEST_WIDTH-1){1'b0}}, 1'b1};
                    esc_next   = 1'b0;
                end
                else if (cur_byte == CH_LBRACK)
                begin
                    bracket_next = inc_sat(bracket_reg);
                end
                else if (cur_byte == CH_RBRACK)
                begin
                    bracket_next = dec_floor(bracket_reg);
                    if (dec_floor(bracket_reg) == '0)
                    begin
                        close_hit = 1'b1;
                        go_idle   = 1'b1;
                    end
                end
            end
            MODE_ARRAY_STR:
            begin
                esc_next   = str_esc;
                paren_next = str_paren;
                if (str_closed)
                begin
                    mode_next = MODE_ARRAY;
                    esc_next  = 1'b0;
                end
            end
            MODE_NAME, MODE_OPER:
            begin
                if (is_ws(cur_byte) || is_delim(cur_byte))
                begin
                    close_hit     = 1'b1;
                    close_kind    = (mode_reg == MODE_NAME) ? KIND_OTHER : KIND_OPER;
                    close_at_next = 1'b0;
                    go_idle       = 1'b1;
                    fresh         = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (!is_num_char(cur_byte))
                begin
                    close_hit     = 1'b1;
                    close_kind    = KIND_NUMBER;
                    close_at_next = 1'b0;
                    go_idle       = 1'b1;
                    fresh         = 1'b1;
                end
            end
            default:
            begin
                go_idle = 1'b1;
                fresh   = 1'b1;
            end
        endcase

        if (go_idle)
        begin
            mode_next    = MODE_IDLE;
            esc_next     = 1'b0;
            paren_next   = '0;
            bracket_next = '0;
            angle_next   = '0;
            half_next    = HALF_NONE;
        end

        // start of whatever follows
        if (fresh && !is_ws(cur_byte))
        begin
            start_next = offset_reg;
            esc_next   = 1'b0;
            half_next  = HALF_NONE;
            if (cur_byte == CH_PERCENT)
            begin
                mode_next = MODE_COMMENT;
            end
            else if (cur_byte == CH_LPAREN)
            begin
                mode_next  = MODE_LIT;
                paren_next = {{(NEST_WIDTH-1){1'b0}}, 1'b1};
            end
            else if (cur_byte == CH_LT)
            begin
                mode_next = MODE_AFTER_LT;
            end
            else if (cur_byte == CH_LBRACK)
            begin
                mode_next    = MODE_ARRAY;
                bracket_next = {{(NEST_WIDTH-1){1'b0}}, 1'b1};
            end
            else if (cur_byte == CH_SLASH)
            begin
                mode_next = MODE_NAME;
            end
            else if (is_num_char(cur_byte))
            begin
                mode_next = MODE_NUMBER;
            end
            else if (is_delim(cur_byte))
            begin
                delim_hit = 1'b1;
            end
            else
            begin
                mode_next = MODE_OPER;
            end
        end

        start_mid = start_next;

        // stream end closes the open token and starts over
        if (beat.is_last)
        begin
            unique case (mode_next)
                MODE_NUMBER:
                begin
                    tail_hit  = 1'b1;
                    tail_kind = KIND_NUMBER;
                end
                MODE_OPER:
                begin
                    tail_hit  = 1'b1;
                    tail_kind = KIND_OPER;
                end
                MODE_LIT, MODE_AFTER_LT, MODE_HEX, MODE_DICT, MODE_ARRAY,
                MODE_ARRAY_STR, MODE_NAME:
                begin
                    tail_hit  = 1'b1;
                    tail_kind = KIND_OTHER;
                end
                default:
                begin
                    tail_hit = 1'b0;
                end
            endcase
            mode_next    = MODE_IDLE;
            esc_next     = 1'b0;
            paren_next   = '0;
            bracket_next = '0;
            angle_next   = '0;
            half_next    = HALF_NONE;
            offset_next  = '0;
            start_next   = '0;
        end
    end

    // pack the records of this byte in order
    always_comb
    begin
        group   = '0;
        rec_cnt = 2'd0;
        if (close_hit)
        begin
            group.recs[rec_cnt] = '{kind: close_kind,
                                    pos_begin: PCTS_POS_WIDTH'(start_reg),
                                    pos_end: close_at_next ? PCTS_POS_WIDTH'(off_plus)
                                                           : PCTS_POS_WIDTH'(offset_reg)};
            rec_cnt = rec_cnt + 2'd1;
        end
        if (delim_hit)
        begin
            group.recs[rec_cnt] = '{kind: KIND_OPER,
                                    pos_begin: PCTS_POS_WIDTH'(offset_reg),
                                    pos_end: PCTS_POS_WIDTH'(off_plus)};
            rec_cnt = rec_cnt + 2'd1;
        end
        if (tail_hit)
        begin
            group.recs[rec_cnt] = '{kind: tail_kind,
                                    pos_begin: PCTS_POS_WIDTH'(start_mid),
                                    pos_end: PCTS_POS_WIDTH'(off_plus)};
            rec_cnt = rec_cnt + 2'd1;
        end
        if (beat.is_last)
        begin
            group.recs[rec_cnt] = '{kind: KIND_END,
                                    pos_begin: PCTS_POS_WIDTH'(off_plus),
                                    pos_end: PCTS_POS_WIDTH'(off_plus)};
            rec_cnt = rec_cnt + 2'd1;
        end
        group.count = rec_cnt;
    end

    assign push       = beat_accept && (close_hit || delim_hit || beat.is_last);
    assign push_group = group;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            esc_reg     <= 1'b0;
            paren_reg   <= '0;
            bracket_reg <= '0;
            angle_reg   <= '0;
            half_reg    <= HALF_NONE;
            offset_reg  <= '0;
            start_reg   <= '0;
        end
        else if (beat_accept)
        begin
            mode_reg    <= mode_next;
            esc_reg     <= esc_next;
            paren_reg   <= paren_next;
            bracket_reg <= bracket_next;
            angle_reg   <= angle_next;
            half_reg    <= half_next;
            offset_reg  <= offset_next;
            start_reg   <= start_next;
        end
    end

endmodule

>>> rtl/pcts_queue.sv
`timescale 1ns / 1ps
// short queue of per-byte result groups between front and back end
// depends on pcts_pkg

module pcts_queue
    import pcts_pkg::*;
#(
    parameter int DEPTH = PCTS_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tok_group_t push_group,
    output logic       full,
    output logic       head_valid,
    output tok_group_t head_group,
    input  logic       pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tok_group_t       ent_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_group = ent_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/pcts_back.sv
`timescale 1ns / 1ps
// back end: sends the records of the head group one beat at a time
// depends on pcts_pkg

module pcts_back
    import pcts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  tok_group_t head_group,
    output logic       pop,
    output logic       token_valid,
    input  logic       token_ready,
    output out_beat_t  token_data
);

    logic [1:0] idx_reg, idx_next;
    tok_rec_t   cur_rec;
    logic       at_last;
    logic       sent;

    assign cur_rec     = head_group.recs[idx_reg];
    assign at_last     = (idx_reg == head_group.count - 2'd1);
    assign token_valid = head_valid;
    assign sent        = token_valid && token_ready;
    assign pop         = sent && at_last;

    assign token_data.token_kind  = cur_rec.kind;
    assign token_data.token_begin = cur_rec.pos_begin;
    assign token_data.token_end   = cur_rec.pos_end;
    assign token_data.last_result = at_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (sent)
        begin
            idx_next = at_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

>>> rtl/pdf_content_token_splitter_top.sv
`timescale 1ns / 1ps
// top level of the content stream token splitter: front scanner, group queue, back end
// depends on pcts_pkg, pcts_front, pcts_queue, pcts_back
//
// usage
//   byte channel (byte_valid / byte_ready / byte_data): one stream byte per beat, is_last
//   marks the final byte of a stream; the next byte after it starts a new stream at offset 0
//   token channel (token_valid / token_ready / token_data): one token per beat with kind,
//   begin offset, exclusive end offset and last_result on the final token of a byte
//   a byte is scanned in the cycle it is accepted; its tokens (up to three), if any, are
//   queued as one group behind any earlier groups and offered from the queue head in turn
//   one byte per cycle is taken while the queue is not full; the back end sends one token
//   per cycle while token_ready is high, and holds each group until its last token is sent
//   the queue holds QUEUE_DEPTH groups; byte_ready drops only when it is full, so a
//   stalled receiver backs up into the byte side after that many groups
//   byte_ready does not depend on token_ready in the same cycle
//   reset clears the scanner to idle, offsets to zero and empties the queue

module pdf_content_token_splitter_top
    import pcts_pkg::*;
#(
    parameter int OFFSET_WIDTH = PCTS_OFFSET_WIDTH,
    parameter int NEST_WIDTH   = PCTS_NEST_WIDTH,
    parameter int QUEUE_DEPTH  = PCTS_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  in_beat_t  byte_data,
    output logic      token_valid,
    input  logic      token_ready,
    output out_beat_t token_data
);

    logic       beat_accept;
    logic       push;
    tok_group_t push_group;
    logic       q_full;
    logic       head_valid;
    tok_group_t head_group;
    logic       pop;

    assign byte_ready  = !q_full;
    assign beat_accept = byte_valid && byte_ready;

    pcts_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .NEST_WIDTH   (NEST_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat_accept (beat_accept),
        .beat        (byte_data),
        .push        (push),
        .push_group  (push_group)
    );

    pcts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .full       (q_full),
        .head_valid (head_valid),
        .head_group (head_group),
        .pop        (pop)
    );

    pcts_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_group  (head_group),
        .pop         (pop),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_data  (token_data)
    );

endmodule

>>> rtl/pcts_checker.sv
`timescale 1ns / 1ps
// port-level checks on the token side of the splitter, bound to the top level
// depends on pcts_pkg and pdf_content_token_splitter_top

module pcts_checker
    import pcts_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      token_valid,
    input logic      token_ready,
    input out_beat_t token_data
);

    // a stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !token_ready |=> token_valid && $stable(token_data))
        else $error("token beat changed while stalled");

    // end of stream is always the final token of its byte
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_data.token_kind == KIND_END |-> token_data.last_result)
        else $error("end token without last_result");

    // end of stream is empty
    a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_data.token_kind == KIND_END |->
            token_data.token_begin == token_data.token_end)
        else $error("end token with nonzero length");

    // more tokens of the same byte follow at once
    a_group_cont: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_ready && !token_data.last_result |=> token_valid)
        else $error("token group cut short");

endmodule

bind pdf_content_token_splitter_top pcts_checker u_pcts_checker (.*);

>>> dv/tb_pdf_content_token_splitter_top.sv
`timescale 1ns / 1ps
// testbench for pdf_content_token_splitter_top: directed and random content streams with idling
// tokens are predicted by a scoreboard class; depends on pcts_pkg and the top level

module tb_pdf_content_token_splitter_top;
    import pcts_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_TICKS   = 80;
    localparam int RANDOM_BYTES = 200;

    localparam logic [7:0] NEST_TOP  = 8'hFF;

    class token_scoreboard;
        scan_mode_t  mode;
        bit          esc;
        logic [7:0]  paren_lvl;
        logic [7:0]  brack_lvl;
        logic [7:0]  angle_lvl;
        logic [1:0]  half;
        logic [31:0] pos;
        logic [31:0] tok_start;
        out_beat_t   expected_tokens[$];
        int          fail_count;
        int          mismatch_count;

        function new();
            clear_scan();
            pos = '0;
            tok_start = '0;
            fail_count = 0;
            mismatch_count = 0;
        endfunction

        function void clear_scan();
            mode = MODE_IDLE;
            esc = 1'b0;
            paren_lvl = '0;
            brack_lvl = '0;
            angle_lvl = '0;
            half = HALF_NONE;
        endfunction

        function bit is_space(logic [7:0] c);
            case (c)
                CH_NUL, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SP: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function bit is_break(logic [7:0] c);
            case (c)
                CH_LPAREN, CH_RPAREN, CH_LT, CH_GT, CH_LBRACK, CH_RBRACK,
                CH_LBRACE, CH_RBRACE, CH_SLASH, CH_PERCENT: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function bit is_numeric(logic [7:0] c);
            return c inside {[CH_ZERO:CH_NINE], CH_PLUS, CH_MINUS, CH_DOT};
        endfunction

        function logic [7:0] bump(logic [7:0] d);
            return (d == NEST_TOP) ? d : d + 8'd1;
        endfunction

        function void add_token(logic [1:0] kind, logic [31:0] b, logic [31:0] e);
            out_beat_t t;
            t.token_kind  = kind;
            t.token_begin = b;
            t.token_end   = e;
            t.last_result = 1'b0;
            expected_tokens.insert(expected_tokens.size(), t);
        endfunction

        // returns 1 when the string closes
        function bit string_step(logic [7:0] c);
            if (esc)
            begin
                esc = 1'b0;
                return 1'b0;
            end
            if (c == CH_BSLASH)
                esc = 1'b1;
            else if (c == CH_LPAREN)
                paren_lvl = bump(paren_lvl);
            else if (c == CH_RPAREN)
            begin
                if (paren_lvl != 0)
                    paren_lvl = paren_lvl - 8'd1;
                return paren_lvl == 0;
            end
            return 1'b0;
        endfunction

        function void start_token(logic [7:0] c, logic [31:0] here, logic [31:0] nxt);
            if (is_space(c))
                return;
            tok_start = here;
            esc = 1'b0;
            half = HALF_NONE;
            if (c == CH_PERCENT)
                mode = MODE_COMMENT;
            else if (c == CH_LPAREN)
            begin
                mode = MODE_LIT;
                paren_lvl = 8'd1;
            end
            else if (c == CH_LT)
                mode = MODE_AFTER_LT;
            else if (c == CH_LBRACK)
            begin
                mode = MODE_ARRAY;
                brack_lvl = 8'd1;
            end
            else if (c == CH_SLASH)
                mode = MODE_NAME;
            else if (is_numeric(c))
                mode = MODE_NUMBER;
            else if (is_break(c))
                add_token(KIND_OPER, here, nxt);
            else
                mode = MODE_OPER;
        endfunction

        function void note_byte(in_beat_t beat);
            logic [7:0]  c;
            logic [31:0] here;
            logic [31:0] nxt;
            logic [1:0]  held;
            bit          rescan;
            int          base;
            c = beat.data_byte;
            here = pos;
            nxt = pos + 32'd1;
            rescan = 1'b0;
            base = expected_tokens.size();
            case (mode)
                MODE_COMMENT:
                    if (c == CH_LF || c == CH_CR)
                        mode = MODE_IDLE;
                MODE_LIT:
                    if (string_step(c))
                    begin
                        add_token(KIND_OTHER, tok_start, nxt);
                        clear_scan();
                    end
                MODE_AFTER_LT:
                begin
                    if (c == CH_LT)
                    begin
                        mode = MODE_DICT;
                        angle_lvl = 8'd1;
                        half = HALF_NONE;
                    end
                    else if (c == CH_GT)
                    begin
                        add_token(KIND_OTHER, tok_start, nxt);
                        clear_scan();
                    end
                    else
                        mode = MODE_HEX;
                end
                MODE_HEX:
                    if (c == CH_GT)
                    begin
                        add_token(KIND_OTHER, tok_start, nxt);
                        clear_scan();
                    end
                MODE_DICT:
                begin
                    held = half;
                    half = HALF_NONE;
                    if (held == HALF_LT && c == CH_LT)
                        angle_lvl = bump(angle_lvl);
                    else if (held == HALF_GT && c == CH_GT)
                    begin
                        if (angle_lvl != 0)
                            angle_lvl = angle_lvl - 8'd1;
                        if (angle_lvl == 0)
                        begin
                            add_token(KIND_OTHER, tok_start, nxt);
                            clear_scan();
                        end
                    end
                    else if (c == CH_LT)
                        half = HALF_LT;
                    else if (c == CH_GT)
                        half = HALF_GT;
                end
                MODE_ARRAY:
                begin
                    if (c == CH_LPAREN)
                    begin
                        mode = MODE_ARRAY_STR;
                        paren_lvl = 8'd1;
                        esc = 1'b0;
                    end
                    else if (c == CH_LBRACK)
                        brack_lvl = bump(brack_lvl);
                    else if (c == CH_RBRACK)
                    begin
                        if (brack_lvl != 0)
                            brack_lvl = brack_lvl - 8'd1;
                        if (brack_lvl == 0)
                        begin
                            add_token(KIND_OTHER, tok_start, nxt);
                            clear_scan();
                        end
                    end
                end
                MODE_ARRAY_STR:
                    if (string_step(c))
                    begin
                        mode = MODE_ARRAY;
                        esc = 1'b0;
                    end
                MODE_NAME, MODE_OPER:
                    if (is_space(c) || is_break(c))
                    begin
                        add_token(mode == MODE_NAME ? KIND_OTHER : KIND_OPER, tok_start, here);
                        clear_scan();
                        rescan = 1'b1;
                    end
                MODE_NUMBER:
                    if (!is_numeric(c))
                    begin
                        add_token(KIND_NUMBER, tok_start, here);
                        clear_scan();
                        rescan = 1'b1;
                    end
                default:
                begin
                    clear_scan();
                    rescan = 1'b1;
                end
            endcase
            if (rescan)
                start_token(c, here, nxt);
            pos = nxt;
            if (beat.is_last)
            begin
                case (mode)
                    MODE_IDLE, MODE_COMMENT: ;
                    MODE_NUMBER: add_token(KIND_NUMBER, tok_start, nxt);
                    MODE_OPER:   add_token(KIND_OPER, tok_start, nxt);
                    default:     add_token(KIND_OTHER, tok_start, nxt);
                endcase
                add_token(KIND_END, nxt, nxt);
                clear_scan();
                pos = '0;
                tok_start = '0;
            end
            if (expected_tokens.size() > base)
                expected_tokens[expected_tokens.size() - 1].last_result = 1'b1;
        endfunction

        function void check_token(out_beat_t got);
            out_beat_t want;
            if (expected_tokens.size() == 0)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected token: kind %0d begin %0d end %0d last %0d",
                             got.token_kind, got.token_begin, got.token_end, got.last_result);
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_kind !== want.token_kind || got.token_begin !== want.token_begin ||
                got.token_end !== want.token_end || got.last_result !== want.last_result)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("token mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                             want.token_kind, want.token_begin, want.token_end,
                             want.last_result, got.token_kind, got.token_begin,
                             got.token_end, got.last_result);
            end
        endfunction
    endclass

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      byte_valid  = 1'b0;
    in_beat_t  byte_data   = '0;
    logic      token_ready = 1'b0;
    logic      byte_ready;
    logic      token_valid;
    out_beat_t token_data;

    token_scoreboard sb = new();
    logic [7:0]      stream_q[$];
    bit              steady = 1'b0;
    int              hold_req = 0;
    int              random_sent = 0;

    always #1 clk = ~clk;

    pdf_content_token_splitter_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_data   (byte_data),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_data  (token_data)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
                sb.note_byte(byte_data);
            if (token_valid && token_ready)
                sb.check_token(token_data);
        end
    end

    // stream builders

    function automatic void put(logic [7:0] c);
        stream_q.insert(stream_q.size(), c);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endfunction

    function automatic logic [7:0] any_but(logic [7:0] x, logic [7:0] y, logic [7:0] z);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == x || c == y || c == z);
        return c;
    endfunction

    function automatic logic [7:0] oper_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (sb.is_space(c) || sb.is_break(c) || sb.is_numeric(c));
        return c;
    endfunction

    function automatic void add_number();
        string digits;
        digits = "0123456789+-.";
        repeat ($urandom_range(1, 4))
            put(digits[$urandom_range(0, 12)]);
    endfunction

    function automatic void add_oper();
        repeat ($urandom_range(1, 3))
            put(oper_char());
    endfunction

    function automatic void add_name();
        put(CH_SLASH);
        repeat ($urandom_range(0, 4))
            put(oper_char());
    endfunction

    function automatic void add_literal();
        int depth;
        depth = 1;
        put(CH_LPAREN);
        repeat ($urandom_range(0, 10))
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    put(CH_LPAREN);
                    depth++;
                end
                1:
                    if (depth > 1)
                    begin
                        put(CH_RPAREN);
                        depth--;
                    end
                2:
                begin
                    put(CH_BSLASH);
                    put(8'($urandom_range(0, 255)));
                end
                default: put(any_but(CH_LPAREN, CH_RPAREN, CH_BSLASH));
            endcase
        end
        repeat (depth)
            put(CH_RPAREN);
    endfunction

    function automatic void add_hex();
        string hexd;
        hexd = "0123456789abcdefABCDEF";
        put(CH_LT);
        if ($urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 6))
                put(hexd[$urandom_range(0, 21)]);
        put(CH_GT);
    endfunction

    function automatic void add_dict();
        int depth;
        depth = 1;
        put(CH_LT);
        put(CH_LT);
        repeat ($urandom_range(0, 8))
        begin
            case ($urandom_range(0, 6))
                0:
                begin
                    put(CH_LT);
                    put(CH_LT);
                    depth++;
                end
                1:
                    if (depth > 1)
                    begin
                        put(CH_GT);
                        put(CH_GT);
                        depth--;
                    end
                2:
                begin
                    put(CH_LT);
                    put(any_but(CH_LT, CH_GT, CH_GT));
                end
                3:
                begin
                    put(CH_GT);
                    put(any_but(CH_LT, CH_GT, CH_GT));
                end
                4: add_name();
                5: put(CH_SP);
                default: add_number();
            endcase
        end
        repeat (depth)
        begin
            put(CH_GT);
            put(CH_GT);
        end
    endfunction

    function automatic void add_array();
        int depth;
        depth = 1;
        put(CH_LBRACK);
        repeat ($urandom_range(0, 8))
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    put(CH_LBRACK);
                    depth++;
                end
                1:
                    if (depth > 1)
                    begin
                        put(CH_RBRACK);
                        depth--;
                    end
                2: add_literal();
                3: put(any_but(CH_LPAREN, CH_LBRACK, CH_RBRACK));
                4: put(CH_SP);
                default: add_number();
            endcase
        end
        repeat (depth)
            put(CH_RBRACK);
    endfunction

    function automatic void add_comment();
        put(CH_PERCENT);
        repeat ($urandom_range(0, 5))
            put(any_but(CH_LF, CH_CR, CH_LF));
        put($urandom_range(0, 1) == 1 ? CH_LF : CH_CR);
    endfunction

    function automatic void add_gap();
        logic [7:0] spaces[6];
        spaces = '{CH_NUL, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SP};
        repeat ($urandom_range(0, 2))
            put(spaces[$urandom_range(0, 5)]);
    endfunction

    function automatic void build_stream();
        logic [7:0] lone[5];
        int         keep;
        lone = '{CH_RPAREN, CH_GT, CH_RBRACK, CH_LBRACE, CH_RBRACE};
        stream_q.delete();
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 10))
                0, 1: add_number();
                2:    add_oper();
                3:    add_name();
                4:    add_literal();
                5:    add_hex();
                6:    add_dict();
                7:    add_array();
                8:    add_comment();
                9:    put(lone[$urandom_range(0, 4)]);
                default: put(8'($urandom_range(0, 255)));
            endcase
            add_gap();
        end
        // cut some streams short, sometimes inside a token
        if ($urandom_range(0, 5) == 0 && stream_q.size() > 1)
        begin
            keep = $urandom_range(1, stream_q.size() - 1);
            stream_q = stream_q[0:keep-1];
        end
    endfunction

    // drivers

    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= '{data_byte: c, is_last: last};
        do
            @(posedge clk);
        while (!byte_ready);
    endtask

    task automatic play_stream();
        for (int i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i], i == stream_q.size() - 1);
        stream_q.delete();
    endtask

    initial
    begin : receiver
        int gap;
        @(posedge clk);
        forever
        begin
            if (hold_req > 0)
            begin
                gap = hold_req;
                hold_req = 0;
            end
            else
                gap = steady ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                token_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            token_ready <= 1'b1;
            do
                @(posedge clk);
            while (!token_valid);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (byte_valid && byte_ready) || (token_valid && token_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // operator cut by a string open at stream end: three tokens from one beat
        put(8'hFF);
        put(CH_LPAREN);
        play_stream();
        put_text("7/");
        play_stream();
        put_text(")>]{}");
        play_stream();
        put_text("(\\))");
        play_stream();
        put_text("<><<>>%\n<");
        play_stream();
        put_text("[(])]");
        put(CH_NUL);
        play_stream();

        // receiver stalls while short numbers pile up
        steady = 1'b1;
        hold_req = HOLD_TICKS;
        put_text("1 2 3 4 5 6 7 8 9 10 11 12 13 ");
        play_stream();
        steady = 1'b0;

        while (random_sent < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 3) == 0)
                steady = ~steady;
            build_stream();
            random_sent += stream_q.size();
            play_stream();
        end
        byte_valid <= 1'b0;

        while (sb.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (sb.fail_count == 0 && sb.expected_tokens.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/pcts_pkg.sv
rtl/pcts_front.sv
rtl/pcts_queue.sv
rtl/pcts_back.sv
rtl/pdf_content_token_splitter_top.sv
rtl/pcts_checker.sv
dv/tb_pdf_content_token_splitter_top.sv
